/* rtl/core/ade_pkg.sv */
// Shared types and constants for the array deque engine.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package ade_pkg;

  localparam int unsigned ADE_DEPTH   = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned ACT_W       = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_REAR  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_LIST       = 3'd4,
    ACT_SEARCH     = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOTFOUND  = 2'd3
  } st_e;

  typedef enum logic [2:0] {
    K_NONE,
    K_PUSH,
    K_POP,
    K_LIST,
    K_SEARCH
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEC,
    S_POP,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic latch;
    logic single;
    logic pop_rd;
    logic pop_done;
    logic scan_rd;
    logic scan_emit;
    logic scan_next;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  empty;
    logic  out_free;
    logic  scan_last;
    logic  match;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/array_deque_engine.sv */
// Top level of the array deque engine: joins ade_ctrl and ade_dp.
// Depends on ade_pkg, ade_ctrl, ade_dp and ade_ram.
`default_nettype none

// The block keeps a double-ended queue in a linear, non-wrapping array of
// DEPTH words and takes one request at a time. A push, an overflow or an
// underflow answer is loaded into the result register from the decode state;
// a pop is loaded from the pop state after a read, because the slot RAM has
// a registered read. List and search walk the slot RAM one entry per cycle
// from head toward tail, a list only while the result register is free. The
// result register lets the last result of a request wait on the master side
// while the next request is already taken; a stall on the master side holds
// a scan in place without losing entries. Action codes six and seven are
// dropped without a result.

module array_deque_engine
  import ade_pkg::*;
#(
  parameter int unsigned DEPTH = ADE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0: action (3), value (32), zero fill (5).
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // Fields from bit 0: status (2), data (32), position (4), zero fill (2).
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  cmd_t              cmd;
  sts_t              sts;
  st_e               status;
  logic [WORD_W-1:0] data;
  logic [POS_W-1:0]  position;

  ade_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ade_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .action_i   (s_axis_tdata[2:0]),
    .value_i    (s_axis_tdata[34:3]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_o   (status),
    .data_o     (data),
    .position_o (position),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, position, data, status};

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.single || cmd.pop_done || cmd.scan_emit) |-> sts.out_free)
    else $error("result loaded while the output register is occupied");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.latch, cmd.single, cmd.pop_rd, cmd.pop_done, cmd.scan_rd,
              cmd.scan_next}))
    else $error("conflicting datapath commands");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("new request taken while one is in progress");

  a_empty_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.single && sts.kind == K_PUSH && sts.empty) |=> !sts.empty)
    else $error("push into an empty deque left it empty");
`endif

endmodule

`default_nettype wire

/* rtl/core/ade_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used by the deque datapath for the slot storage.
`default_nettype none

module ade_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/ade_ctrl.sv */
// Sequencing state machine of the array deque engine.
// Depends on ade_pkg; drives commands to ade_dp and reads its status.
`default_nettype none

module ade_ctrl
  import ade_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.kind == K_NONE) begin
          state_d = S_IDLE;
        end else if (sts_i.kind == K_PUSH || sts_i.empty) begin
          if (sts_i.out_free) begin
            state_d = S_IDLE;
          end
        end else if (sts_i.kind == K_POP) begin
          state_d = S_POP;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_POP: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts_i.kind == K_LIST) begin
          if (sts_i.out_free && sts_i.scan_last) begin
            state_d = S_IDLE;
          end
        end else if (sts_i.match || sts_i.scan_last) begin
          if (sts_i.out_free) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      S_DEC: begin
        if (sts_i.kind == K_NONE) begin
          cmd_o = '0;
        end else if (sts_i.kind == K_PUSH || sts_i.empty) begin
          cmd_o.single = sts_i.out_free;
        end else if (sts_i.kind == K_POP) begin
          cmd_o.pop_rd = 1'b1;
        end else begin
          cmd_o.scan_rd = 1'b1;
        end
      end
      S_POP: begin
        cmd_o.pop_done = sts_i.out_free;
      end
      S_SCAN: begin
        if (sts_i.kind == K_LIST) begin
          cmd_o.scan_emit = sts_i.out_free;
          cmd_o.scan_next = sts_i.out_free && !sts_i.scan_last;
        end else if (sts_i.match || sts_i.scan_last) begin
          cmd_o.scan_emit = sts_i.out_free;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/ade_dp.sv */
// Datapath of the array deque engine: head, tail and empty registers, the
// slot RAM, the scan index and the result register. Depends on ade_pkg, ade_ram.
`default_nettype none

module ade_dp
  import ade_pkg::*;
#(
  parameter int unsigned DEPTH = ADE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  input  wire logic [ACT_W-1:0]  action_i,
  input  wire logic [WORD_W-1:0] value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output st_e                    status_o,
  output logic [WORD_W-1:0]      data_o,
  output logic [POS_W-1:0]       position_o,
  output logic                   last_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  logic [ACT_W-1:0]  act_q;
  logic [WORD_W-1:0] val_q;
  logic [AW-1:0]     head_q, head_d, tail_q, tail_d, idx_q;
  logic              empty_q, empty_d;
  logic [CNT_W-1:0]  cnt_q;

  logic              out_valid_q;
  st_e               st_q, st_d;
  logic [WORD_W-1:0] dat_q, dat_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              last_q, last_d;
  logic              load;

  logic [AW-1:0]       slot;
  logic [AW+POS_W-1:0] slot_ext;
  logic                we;
  logic                re;
  logic [AW-1:0]       raddr;
  logic [WORD_W-1:0]   rdata;
  kind_e               kind;
  logic                out_free;
  logic                scan_last;
  logic                pop_front;

  always_comb begin
    case (act_q)
      ACT_PUSH_REAR, ACT_PUSH_FRONT: kind = K_PUSH;
      ACT_POP_FRONT, ACT_POP_REAR:   kind = K_POP;
      ACT_LIST:                      kind = K_LIST;
      ACT_SEARCH:                    kind = K_SEARCH;
      default:                       kind = K_NONE;
    endcase
  end

  assign pop_front = (act_q == ACT_POP_FRONT);
  assign out_free  = !out_valid_q || out_ready_i;
  assign scan_last = (idx_q == tail_q) ||
                     ((kind == K_LIST) && (cnt_q == CNT_W'(MAX_RESULTS - 1)));

  assign sts_o.kind      = kind;
  assign sts_o.empty     = empty_q;
  assign sts_o.out_free  = out_free;
  assign sts_o.scan_last = scan_last;
  assign sts_o.match     = (rdata == val_q);

  // Slot that the current command writes, pops or reports, and the next head, tail and empty values.
  always_comb begin
    slot    = idx_q;
    we      = 1'b0;
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    if (cmd_i.single && kind == K_PUSH) begin
      if (empty_q) begin
        slot    = '0;
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b0;
        we      = 1'b1;
      end else if (act_q == ACT_PUSH_REAR) begin
        if (tail_q != LastSlot) begin
          slot   = tail_q + AW'(1);
          tail_d = slot;
          we     = 1'b1;
        end
      end else if (head_q != '0) begin
        slot   = head_q - AW'(1);
        head_d = slot;
        we     = 1'b1;
      end
    end else if (cmd_i.pop_done) begin
      slot = pop_front ? head_q : tail_q;
      if (head_q == tail_q) begin
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b1;
      end else if (pop_front) begin
        head_d = head_q + AW'(1);
      end else begin
        tail_d = tail_q - AW'(1);
      end
    end
  end

  assign slot_ext = {{POS_W{1'b0}}, slot};

  always_comb begin
    load   = 1'b0;
    st_d   = ST_OK;
    dat_d  = '0;
    pos_d  = '0;
    last_d = 1'b1;
    if (cmd_i.single) begin
      load = 1'b1;
      if (kind != K_PUSH) begin
        st_d = ST_UNDERFLOW;
      end else if (we) begin
        pos_d = slot_ext[POS_W-1:0];
      end else begin
        st_d = ST_OVERFLOW;
      end
    end else if (cmd_i.pop_done) begin
      load  = 1'b1;
      dat_d = rdata;
      pos_d = slot_ext[POS_W-1:0];
    end else if (cmd_i.scan_emit) begin
      load = 1'b1;
      if (kind == K_LIST) begin
        dat_d  = rdata;
        pos_d  = slot_ext[POS_W-1:0];
        last_d = scan_last;
      end else if (sts_o.match) begin
        pos_d = slot_ext[POS_W-1:0];
      end else begin
        st_d = ST_NOTFOUND;
      end
    end
  end

  always_comb begin
    re    = cmd_i.pop_rd || cmd_i.scan_rd || cmd_i.scan_next;
    raddr = head_q;
    if (cmd_i.pop_rd && !pop_front) begin
      raddr = tail_q;
    end else if (cmd_i.scan_next) begin
      raddr = idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q <= action_i;
      val_q <= value_i;
    end
    if (cmd_i.scan_rd) begin
      idx_q <= head_q;
      cnt_q <= '0;
    end else if (cmd_i.scan_next) begin
      idx_q <= idx_q + AW'(1);
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (load) begin
      st_q   <= st_d;
      dat_q  <= dat_d;
      pos_q  <= pos_d;
      last_q <= last_d;
    end
  end

  ade_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(slot),
    .wdata_i(val_q),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = st_q;
  assign data_o      = dat_q;
  assign position_o  = pos_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for array_deque_engine: a predictor class tracks the deque contents
// and checks every result transfer, while plain tasks drive random and directed requests.
// Depends on ade_pkg and the array_deque_engine RTL.

module testbench;
  import ade_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

  typedef struct packed {
    st_e               status;
    logic [WORD_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              last;
  } answer_t;

  class deque_tracker;
    logic [WORD_W-1:0] mem [ADE_DEPTH];
    int                head;
    int                tail;
    bit                empty;
    answer_t           expected_answers[$];
    int                errors;
    int                requests;
    int                answers;
    int                overflows;
    int                underflows;
    int                misses;

    function new();
      head = 0;
      tail = 0;
      empty = 1'b1;
      foreach (mem[i]) mem[i] = '0;
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction

    function void expect_answer(st_e status, logic [WORD_W-1:0] data, int pos, logic last);
      answer_t a;
      a.status = status;
      a.data = data;
      a.pos = pos[POS_W-1:0];
      a.last = last;
      expected_answers.push_back(a);
      if (status == ST_OVERFLOW) overflows++;
      if (status == ST_UNDERFLOW) underflows++;
      if (status == ST_NOTFOUND) misses++;
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [WORD_W-1:0] val);
      int  slot;
      int  n;
      bit  fin;
      if (act > ACT_SEARCH) return;
      requests++;
      if (act == ACT_PUSH_REAR || act == ACT_PUSH_FRONT) begin
        if (empty) begin
          slot = 0;
          head = 0;
          tail = 0;
          empty = 1'b0;
        end else if (act == ACT_PUSH_REAR) begin
          if (tail >= ADE_DEPTH - 1) begin
            expect_answer(ST_OVERFLOW, '0, 0, 1'b1);
            return;
          end
          tail++;
          slot = tail;
        end else begin
          if (head == 0) begin
            expect_answer(ST_OVERFLOW, '0, 0, 1'b1);
            return;
          end
          head--;
          slot = head;
        end
        mem[slot] = val;
        expect_answer(ST_OK, '0, slot, 1'b1);
        return;
      end
      if (empty) begin
        expect_answer(ST_UNDERFLOW, '0, 0, 1'b1);
        return;
      end
      if (act == ACT_POP_FRONT || act == ACT_POP_REAR) begin
        slot = (act == ACT_POP_FRONT) ? head : tail;
        expect_answer(ST_OK, mem[slot], slot, 1'b1);
        if (head == tail) begin
          empty = 1'b1;
          head = 0;
          tail = 0;
        end else if (act == ACT_POP_FRONT) begin
          head++;
        end else begin
          tail--;
        end
        return;
      end
      if (act == ACT_LIST) begin
        n = 0;
        for (int i = head; i <= tail && i < ADE_DEPTH; i++) begin
          fin = (i == tail) || (n == MAX_RESULTS - 1);
          expect_answer(ST_OK, mem[i], i, fin);
          n++;
          if (fin) break;
        end
        return;
      end
      for (int i = head; i <= tail && i < ADE_DEPTH; i++) begin
        if (mem[i] == val) begin
          expect_answer(ST_OK, '0, i, 1'b1);
          return;
        end
      end
      expect_answer(ST_NOTFOUND, '0, 0, 1'b1);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_answer(logic [1:0] status, logic [WORD_W-1:0] data, logic [POS_W-1:0] pos,
                      logic last);
      answer_t a;
      if (expected_answers.size() == 0) begin
        report($sformatf("result status %0d data %h position %0d with nothing expected",
                         status, data, pos));
        return;
      end
      a = expected_answers.pop_front();
      answers++;
      if (status !== a.status)
        report($sformatf("status %0d, expected %s", status, a.status.name()));
      if (data !== a.data)
        report($sformatf("data %h, expected %h", data, a.data));
      if (pos !== a.pos)
        report($sformatf("position %0d, expected %0d", pos, a.pos));
      if (last !== a.last)
        report($sformatf("tlast %b, expected %b", last, a.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  bit          calm = 1'b0;
  deque_tracker tracker = new();

  array_deque_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 6);
  end

  // Handshake signals are stable at the falling edge, so a transfer seen here
  // completes at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_answer(m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[37:34],
                           m_axis_tlast);
    end
  end

  task automatic send_request(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] val);
    bit taken;
    while (!calm && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, val, act};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    tracker.note_request(act, val);
  endtask

  task automatic run_random(input int count);
    int               done;
    int               k;
    int               mode;
    int               r;
    logic [ACT_W-1:0] act;
    logic [WORD_W-1:0] val;
    done = 0;
    k = 0;
    mode = 0;
    while (done < count) begin
      if (k % 40 == 0) mode = $urandom_range(2);
      calm = (done >= 120 && done < 220);
      r = $urandom_range(99);
      if (mode == 0) begin
        if (r < 55) act = ACT_PUSH_REAR;
        else if (r < 70) act = ACT_PUSH_FRONT;
        else if (r < 78) act = ACT_POP_FRONT;
        else if (r < 83) act = ACT_POP_REAR;
        else if (r < 91) act = ACT_LIST;
        else act = ACT_SEARCH;
      end else if (mode == 1) begin
        if (r < 10) act = ACT_PUSH_REAR;
        else if (r < 20) act = ACT_PUSH_FRONT;
        else if (r < 45) act = ACT_POP_FRONT;
        else if (r < 70) act = ACT_POP_REAR;
        else if (r < 82) act = ACT_LIST;
        else act = ACT_SEARCH;
      end else begin
        act = ACT_W'($urandom_range(ACT_SEARCH, ACT_PUSH_REAR));
      end
      if ($urandom_range(99) < 3) act = ACT_W'($urandom_range(ACT_SPARE7, ACT_SPARE6));
      r = $urandom_range(99);
      if (act == ACT_SEARCH && !tracker.empty && r < 60) begin
        val = tracker.mem[$urandom_range(tracker.tail, tracker.head)];
      end else if (r < 70) begin
        case ($urandom_range(3))
          0: val = 32'h8000_0000;
          1: val = 32'h7fff_ffff;
          2: val = 32'hffff_ffff;
          default: val = '0;
        endcase
      end else if (r < 85) begin
        val = $urandom_range(3);
      end else begin
        val = $urandom;
      end
      send_request(act, val);
      if (act <= ACT_SEARCH) done++;
      k++;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_request(ACT_POP_FRONT, '0);
    send_request(ACT_POP_REAR, '0);
    send_request(ACT_LIST, '0);
    send_request(ACT_SEARCH, '0);
    send_request(ACT_PUSH_FRONT, 32'h8000_0000);
    send_request(ACT_PUSH_FRONT, 32'h0000_0001);
    send_request(ACT_PUSH_REAR, 32'h7fff_ffff);
    send_request(ACT_PUSH_REAR, 32'hffff_ffff);
    send_request(ACT_SEARCH, 32'h7fff_ffff);
    send_request(ACT_SEARCH, '0);
    send_request(ACT_LIST, '0);
    send_request(ACT_SPARE6, 32'h1234_5678);
    send_request(ACT_SPARE7, 32'hffff_ffff);
    send_request(ACT_POP_FRONT, '0);
    send_request(ACT_PUSH_FRONT, 32'h5555_5555);
    send_request(ACT_POP_REAR, '0);
    send_request(ACT_POP_REAR, '0);
    send_request(ACT_POP_FRONT, '0);
    send_request(ACT_PUSH_REAR, 32'haaaa_aaaa);
    send_request(ACT_POP_REAR, '0);
    run_random(350);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (2 * ADE_DEPTH + 8) @(posedge clk_i);
    $display("Ran %0d requests and checked %0d results, including %0d overflow,",
             tracker.requests, tracker.answers, tracker.overflows);
    $display("%0d underflow and %0d not-found answers.", tracker.underflows, tracker.misses);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* array_deque_engine.f */
rtl/core/ade_pkg.sv
rtl/core/ade_ram.sv
rtl/core/ade_ctrl.sv
rtl/core/ade_dp.sv
rtl/core/array_deque_engine.sv
verif/testbench.sv
